/* sv/irls_pkg.sv */
// shared types and constants for the modulated ir line sensor
// no dependencies; imported by every module of the block
package irls_pkg;

  localparam int NUM_PROBES   = 4;
  localparam int ADC_BITS_DEF = 12;
  localparam int REF_W        = 16;
  localparam int CORR_W       = 16;
  localparam int CFG_W        = 64;

  // position arithmetic: 127 + 0.15 * x, gain in q0.16
  localparam int POS_CENTER = 127;
  localparam int POS_GAIN   = 9830;
  localparam int GAIN_W     = 15;
  localparam int POS_W      = 8;
  // x = diff2 - diff3 - correction, sized for the widest adc setting
  localparam int POS_XW     = 19;

  typedef enum logic [1:0] {
    CFG_LINE_REFS  = 2'd0,
    CFG_BG_REFS    = 2'd1,
    CFG_THRESHOLDS = 2'd2,
    CFG_CENTER     = 2'd3
  } cfg_reg_e;

  // one item between the lane stage and the position stage
  typedef struct packed {
    logic                      emitter;
    logic [NUM_PROBES-1:0]     flags;
    logic signed [POS_XW-1:0]  x;
  } pos_item_t;

endpackage

/* sv/irls_lane.sv */
// one probe lane: on/off readings, difference and windowed flag update
// depends on irls_pkg
module irls_lane import irls_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic                       phase,
  input  logic [ADC_BITS-1:0]        sample,
  input  logic [REF_W-1:0]           line_ref,
  input  logic [REF_W-1:0]           bg_ref,
  input  logic [REF_W-1:0]           thresh,
  output logic signed [ADC_BITS:0]   diff,
  output logic                       flag_next
);

  localparam int DW = ADC_BITS + 1;
  localparam int CW = ((ADC_BITS > REF_W) ? ADC_BITS : REF_W) + 2;

  logic [ADC_BITS-1:0] on_rd;
  logic [ADC_BITS-1:0] off_rd;
  logic                flag;
  logic [ADC_BITS-1:0] on_rd_next;
  logic [ADC_BITS-1:0] off_rd_next;
  logic signed [CW-1:0] diff_x;
  logic signed [CW-1:0] line_x;
  logic signed [CW-1:0] bg_x;
  logic signed [CW-1:0] thr_x;

  // sample lands in the on or off slot depending on the emitter phase
  always_comb begin
    on_rd_next  = phase ? sample : on_rd;
    off_rd_next = phase ? off_rd : sample;
    diff        = $signed({1'b0, on_rd_next}) - $signed({1'b0, off_rd_next});
  end

  // window check in a common signed width
  always_comb begin
    diff_x = {{(CW-DW){diff[DW-1]}}, diff};
    line_x = $signed({{(CW-REF_W){1'b0}}, line_ref});
    bg_x   = $signed({{(CW-REF_W){1'b0}}, bg_ref});
    thr_x  = $signed({{(CW-REF_W){1'b0}}, thresh});
    if (diff_x > line_x && diff_x < bg_x) begin
      flag_next = diff_x > thr_x;
    end else begin
      flag_next = flag;
    end
  end

  // lane state
  always_ff @(posedge clk) begin
    if (rst) begin
      on_rd  <= '0;
      off_rd <= '0;
      flag   <= 1'b0;
    end else if (take) begin
      on_rd  <= on_rd_next;
      off_rd <= off_rd_next;
      flag   <= flag_next;
    end
  end

endmodule

/* sv/irls_merge.sv */
// position stage: constant gain multiply, centering, saturation, output register
// depends on irls_pkg
module irls_merge import irls_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s1_valid,
  input  pos_item_t              s1,
  output logic                   s1_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   emitter_drive,
  output logic [NUM_PROBES-1:0]  line_flags,
  output logic [POS_W-1:0]       line_position
);

  localparam int PW = POS_XW + GAIN_W;
  localparam int SW = PW + 1;
  localparam logic signed [GAIN_W-1:0] GAIN = GAIN_W'(POS_GAIN);
  localparam logic signed [SW-1:0] CENTER_Q16 = SW'(POS_CENTER) <<< 16;

  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] sum;
  logic [POS_W-1:0]     pos;
  logic                 s1_take;
  logic                 out_valid_next;

  // 127 + 0.15 * x in q16, truncated and clamped to a byte
  always_comb begin
    prod = PW'(s1.x) * PW'(GAIN);
    sum  = {prod[PW-1], prod} + CENTER_Q16;
    if (sum[SW-1]) begin
      pos = '0;
    end else if (|sum[SW-2:16+POS_W]) begin
      pos = '1;
    end else begin
      pos = sum[16+POS_W-1:16];
    end
  end

  // output register handshake
  always_comb begin
    s1_stall       = out_valid & out_stall;
    s1_take        = s1_valid & ~s1_stall;
    out_valid_next = s1_take | (out_valid & out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      emitter_drive <= s1.emitter;
      line_flags    <= s1.flags;
      line_position <= pos;
    end
  end

endmodule

/* sv/modulated_ir_line_sensor_unit.sv */
// modulated ir line sensor: four probe lanes, emitter phase, position stage
// the lanes and the position multiply are pipelined: an accepted item is registered
// in the lane stage, then in the output register; one item per cycle unless stalled
// reset: synchronous; clears emitter phase, readings, flags, config and valids
// depends on irls_pkg, irls_lane, irls_merge
module modulated_ir_line_sensor_unit import irls_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [ADC_BITS-1:0]    sample_probe1,
  input  logic [ADC_BITS-1:0]    sample_probe2,
  input  logic [ADC_BITS-1:0]    sample_probe3,
  input  logic [ADC_BITS-1:0]    sample_probe4,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   emitter_drive,
  output logic [NUM_PROBES-1:0]  line_flags,
  output logic [POS_W-1:0]       line_position
);

  localparam int DW = ADC_BITS + 1;

  logic [CFG_W-1:0]         line_refs;
  logic [CFG_W-1:0]         background_refs;
  logic [CFG_W-1:0]         detect_thresholds;
  logic signed [CORR_W-1:0] center_correction;

  logic                     phase;
  logic                     take;
  logic                     s1_valid;
  logic                     s1_valid_next;
  logic                     s1_stall;
  pos_item_t                s1;
  pos_item_t                s1_next;

  logic [ADC_BITS-1:0]      samples   [NUM_PROBES];
  logic signed [DW-1:0]     diffs     [NUM_PROBES];
  logic [NUM_PROBES-1:0]    flag_vec;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_refs         <= '0;
      background_refs   <= '0;
      detect_thresholds <= '0;
      center_correction <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_LINE_REFS:  line_refs         <= cfg_data;
        CFG_BG_REFS:    background_refs   <= cfg_data;
        CFG_THRESHOLDS: detect_thresholds <= cfg_data;
        CFG_CENTER:     center_correction <= $signed(cfg_data[CORR_W-1:0]);
        default: ;
      endcase
    end
  end

  // input handshake and lane stage valid
  always_comb begin
    in_stall      = s1_valid & s1_stall;
    take          = in_valid & ~in_stall;
    s1_valid_next = take | (s1_valid & s1_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
      if (take) begin
        phase <= ~phase;
      end
    end
  end

  assign samples[0] = sample_probe1;
  assign samples[1] = sample_probe2;
  assign samples[2] = sample_probe3;
  assign samples[3] = sample_probe4;

  // one lane per probe; probe1 flag lands in the top bit
  for (genvar i = 0; i < NUM_PROBES; i++) begin : g_lane
    irls_lane #(
      .ADC_BITS(ADC_BITS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .take      (take),
      .phase     (phase),
      .sample    (samples[i]),
      .line_ref  (line_refs[i*REF_W +: REF_W]),
      .bg_ref    (background_refs[i*REF_W +: REF_W]),
      .thresh    (detect_thresholds[i*REF_W +: REF_W]),
      .diff      (diffs[i]),
      .flag_next (flag_vec[NUM_PROBES-1-i])
    );
  end

  // x = diff2 - diff3 - correction, sign extended to the stage width
  always_comb begin
    s1_next.emitter = ~phase;
    s1_next.flags   = flag_vec;
    s1_next.x       = {{(POS_XW-DW){diffs[1][DW-1]}}, diffs[1]}
                    - {{(POS_XW-DW){diffs[2][DW-1]}}, diffs[2]}
                    - {{(POS_XW-CORR_W){center_correction[CORR_W-1]}}, center_correction};
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1 <= s1_next;
    end
  end

  irls_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .s1_valid      (s1_valid),
    .s1            (s1),
    .s1_stall      (s1_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .emitter_drive (emitter_drive),
    .line_flags    (line_flags),
    .line_position (line_position)
  );

  // every accepted item toggles the emitter and fills the lane stage
  a_phase_toggle: assert property (@(posedge clk) disable iff (rst)
    take |=> (phase != $past(phase)) && s1_valid)
    else $error("emitter phase did not toggle on an accepted item");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(phase))
    else $error("emitter phase changed without an item");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_stall) |=> s1_valid && $stable(s1))
    else $error("lane stage item lost while the output is stalled");

  a_emitter_match: assert property (@(posedge clk) disable iff (rst)
    take |=> s1.emitter == phase)
    else $error("staged emitter drive differs from the new phase");

endmodule
